// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers included by rf_power_setpoint_and_bias_loop
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequent holds at the edge after the antecedent
`define RFP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/rfpwr_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpwr_pkg
// types, constants and calibration tables of the tx power regulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfpwr_pkg;

  // grid shape and level offset
  localparam int FREQ_POINTS  = 9;
  localparam int POWER_POINTS = 7;
  localparam int DB_OFFSET_Q4 = 0;

  localparam int ROW_W = $clog2(POWER_POINTS);
  localparam int COL_W = $clog2(FREQ_POINTS);

  // field widths
  localparam int FREQ_W   = 13;
  localparam int PWM_W    = 12;
  localparam int LEVEL_W  = 10;
  localparam int SAMPLE_W = 12;
  localparam int TARGET_W = 11;
  localparam int DEN_W    = 12;

  // frequency grid
  localparam int FREQ_MIN  = 5600;
  localparam int FREQ_MAX  = 6000;
  localparam int FREQ_STEP = 50;

  // reset values and fixed levels
  localparam logic [FREQ_W-1:0]   FREQ_RESET       = 13'd5800;
  localparam logic [PWM_W-1:0]    PWM_LOW_RESET    = 12'd2000;
  localparam logic [PWM_W-1:0]    PWM_HIGH_RESET   = 12'd2500;
  localparam logic [TARGET_W-1:0] OVERDRIVE_TARGET = 11'd1500;
  localparam logic [TARGET_W-1:0] TARGET_MAX       = 11'd2047;
  localparam logic [LEVEL_W-1:0]  LEVEL_OFF_Q4     = 10'd320;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX_Q4     = 10'd512;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_HIGH  = 2'd2;

  // command codes
  localparam logic CMD_SET_POWER = 1'b0;
  localparam logic CMD_TICK      = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [LEVEL_W-1:0]  power_dbm_q4;
    logic [SAMPLE_W-1:0] detector_sample;
  } rfpwr_in_t;

  typedef struct packed {
    logic [PWM_W-1:0]    pwm_duty;
    logic                amp_enable;
    logic [TARGET_W-1:0] detector_target;
  } rfpwr_out_t;

  // level grid points in whole dBm
  localparam logic [5:0] GRID_DBM [POWER_POINTS] = '{
    6'd20, 6'd23, 6'd26, 6'd28, 6'd29, 6'd31, 6'd32};

  // detector set-point per level row and frequency column
  localparam logic [TARGET_W-1:0] CAL_ROM [POWER_POINTS][FREQ_POINTS] = '{
    '{11'd452,  11'd454,  11'd424,  11'd430,  11'd424,  11'd432,  11'd449,
      11'd457,  11'd460},
    '{11'd530,  11'd521,  11'd518,  11'd518,  11'd524,  11'd525,  11'd536,
      11'd548,  11'd562},
    '{11'd672,  11'd651,  11'd667,  11'd664,  11'd678,  11'd678,  11'd688,
      11'd707,  11'd733},
    '{11'd821,  11'd793,  11'd807,  11'd805,  11'd820,  11'd824,  11'd840,
      11'd865,  11'd899},
    '{11'd917,  11'd887,  11'd893,  11'd893,  11'd905,  11'd914,  11'd934,
      11'd964,  11'd1002},
    '{11'd1161, 11'd1130, 11'd1098, 11'd1107, 11'd1107, 11'd1133, 11'd1170,
      11'd1210, 11'd1256},
    '{11'd1314, 11'd1286, 11'd1221, 11'd1237, 11'd1225, 11'd1264, 11'd1314,
      11'd1361, 11'd1409}};

  // calibration lookup, zero outside the grid
  function automatic logic [TARGET_W-1:0] cal_lookup(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
    logic [TARGET_W-1:0] val;
    val = '0;
    if (int'(row) < POWER_POINTS && int'(col) < FREQ_POINTS) begin
      val = CAL_ROM[row][col];
    end
    return val;
  endfunction

  // grid frequency of a column in MHz
  function automatic logic [FREQ_W-1:0] grid_freq(input int idx);
    return FREQ_W'(FREQ_MIN + FREQ_STEP * idx);
  endfunction

  // level grid point in dBm*16
  function automatic logic [9:0] grid_q4(input logic [ROW_W-1:0] row);
    logic [9:0] val;
    val = '0;
    if (int'(row) < POWER_POINTS) begin
      val = {GRID_DBM[row], 4'b0000};
    end
    return val;
  endfunction

  // cell area in dBm*16 by MHz of a level segment
  function automatic logic [DEN_W-1:0] seg_den(input logic [ROW_W-1:0] row);
    logic [DEN_W-1:0] val;
    val = '0;
    for (int i = 0; i < POWER_POINTS - 1; i++) begin
      if (int'(row) == i) begin
        val = DEN_W'(16 * FREQ_STEP * (int'(GRID_DBM[i+1]) - int'(GRID_DBM[i])));
      end
    end
    return val;
  endfunction

endpackage

// ===== sv/rf_power_setpoint_and_bias_loop.sv =====
// ----------------------------------------------------------------------------
// rf_power_setpoint_and_bias_loop
// tx power regulator: detector set-point from a calibration grid and a
// bias pwm loop that steps toward the set-point on every control tick
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | beat
//  in      | sink      | in_valid_i / in_ready_o | rfpwr_in_t
//  out     | source    | out_valid_o/out_ready_i | rfpwr_out_t
//  cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  ticks, power-off, overdrive and the 32 dBm row go from idle straight to write-back.
//  interpolated levels take 6 passes through the shared
//  multiply-accumulate, one range check, 11 restoring divide steps, one
//  write-back; a negative or saturating quotient skips the divide.
//  one beat is in flight at a time; a finished beat waits in the output
//  register, and write-back stalls only while that register is still full.
//  reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rf_power_setpoint_and_bias_loop (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rfpwr_pkg::rfpwr_in_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rfpwr_pkg::rfpwr_out_t               out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rfpwr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rfpwr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int ROW_W = rfpwr_pkg::ROW_W;
  localparam int COL_W = rfpwr_pkg::COL_W;
  localparam int ACC_W = 36;
  localparam int MA_W  = 24;
  localparam int MB_W  = 11;
  localparam int REM_W = rfpwr_pkg::DEN_W + 11;
  localparam int DSR_W = rfpwr_pkg::DEN_W + 10;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [2:0] MAC_LAST = 3'd5;
  localparam logic [3:0] DIV_FIRST = 4'd10;

  // control and architectural state
  logic [2:0]                          state_q, state_d;
  logic [rfpwr_pkg::FREQ_W-1:0]        freq_q;
  logic [rfpwr_pkg::PWM_W-1:0]         pwm_lo_q, pwm_hi_q;
  logic [rfpwr_pkg::PWM_W-1:0]         pwm_q, pwm_d;
  logic [rfpwr_pkg::TARGET_W-1:0]      target_q, target_d;
  logic                                amp_q, amp_d;
  logic                                out_valid_q;
  rfpwr_pkg::rfpwr_out_t               out_q;

  // item and datapath registers
  logic                                cmd_q;
  logic [rfpwr_pkg::LEVEL_W-1:0]       level_q;
  logic [rfpwr_pkg::SAMPLE_W-1:0]      sample_q;
  logic [ROW_W-1:0]                    pr_q, pr_d;
  logic [COL_W-1:0]                    fc_q, fc_d;
  logic [COL_W-1:0]                    ctop_q, ctop_d;
  logic signed [MB_W-1:0]              dxh_q, dxl_q, dxh_d, dxl_d;
  logic [5:0]                          dyh_q, dyl_q, dyh_d, dyl_d;
  logic [2:0]                          step_q;
  logic signed [ACC_W-1:0]             acc_q, acc_d;
  logic signed [MA_W-1:0]              f1_q;
  logic [REM_W-1:0]                    rem_q;
  logic [DSR_W-1:0]                    dsr_q;
  logic [3:0]                          cnt_q;
  logic [rfpwr_pkg::TARGET_W-1:0]      calc_q;

  // front-end signals
  logic                                in_fire;
  logic                                out_free;
  logic [rfpwr_pkg::FREQ_W-1:0]        f_clamp;
  logic [COL_W-1:0]                    col_full;
  logic signed [11:0]                  x_s;
  logic signed [11:0]                  x1_s, x2_s;
  logic [rfpwr_pkg::FREQ_W-1:0]        y1;
  logic                                need_interp;

  // shared multiply-accumulate and divider signals
  logic [ROW_W-1:0]                    rom_row;
  logic [COL_W-1:0]                    rom_col;
  logic [rfpwr_pkg::TARGET_W-1:0]      rom_q;
  logic signed [MA_W-1:0]              mul_a;
  logic signed [MB_W-1:0]              mul_b;
  logic signed [MA_W+MB_W-1:0]         prod;
  logic [rfpwr_pkg::DEN_W-1:0]         den;
  logic                                num_ovf;
  logic [REM_W:0]                      trial;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // frequency clamp and grid column at or below it
  always_comb begin
    if (freq_q < rfpwr_pkg::FREQ_W'(rfpwr_pkg::FREQ_MIN)) begin
      f_clamp = rfpwr_pkg::FREQ_W'(rfpwr_pkg::FREQ_MIN);
    end else if (freq_q > rfpwr_pkg::FREQ_W'(rfpwr_pkg::FREQ_MAX)) begin
      f_clamp = rfpwr_pkg::FREQ_W'(rfpwr_pkg::FREQ_MAX);
    end else begin
      f_clamp = freq_q;
    end
    col_full = '0;
    for (int i = 1; i < rfpwr_pkg::FREQ_POINTS; i++) begin
      if (f_clamp >= rfpwr_pkg::grid_freq(i)) begin
        col_full = COL_W'(i);
      end
    end
    ctop_d = col_full;
    if (int'(col_full) > rfpwr_pkg::FREQ_POINTS - 2) begin
      fc_d = COL_W'(rfpwr_pkg::FREQ_POINTS - 2);
    end else begin
      fc_d = col_full;
    end
    y1    = rfpwr_pkg::grid_freq(int'(fc_d));
    dyl_d = 6'(f_clamp - y1);
    dyh_d = 6'(rfpwr_pkg::FREQ_STEP) - dyl_d;
  end

  // level segment and distances to its grid points
  always_comb begin
    x_s  = $signed({2'b00, in_data_i.power_dbm_q4}) + 12'(rfpwr_pkg::DB_OFFSET_Q4);
    pr_d = '0;
    for (int i = 1; i < rfpwr_pkg::POWER_POINTS - 1; i++) begin
      if (x_s >= $signed({2'b00, rfpwr_pkg::grid_q4(ROW_W'(i))})) begin
        pr_d = ROW_W'(i);
      end
    end
    x1_s  = $signed({2'b00, rfpwr_pkg::grid_q4(pr_d)});
    x2_s  = $signed({2'b00, rfpwr_pkg::grid_q4(pr_d + ROW_W'(1))});
    dxl_d = MB_W'(x_s - x1_s);
    dxh_d = MB_W'(x2_s - x_s);
  end

  assign need_interp = (in_data_i.cmd == rfpwr_pkg::CMD_SET_POWER) &&
                       (in_data_i.power_dbm_q4 >= rfpwr_pkg::LEVEL_OFF_Q4) &&
                       (in_data_i.power_dbm_q4 <  rfpwr_pkg::LEVEL_MAX_Q4);

  // calibration read: four corners during mac passes, top row at write-back
  always_comb begin
    if (state_q == ST_MAC) begin
      rom_row = pr_q + ROW_W'(step_q[0]);
      rom_col = fc_q + COL_W'(step_q[1]);
    end else begin
      rom_row = ROW_W'(rfpwr_pkg::POWER_POINTS - 1);
      rom_col = ctop_q;
    end
    rom_q = rfpwr_pkg::cal_lookup(rom_row, rom_col);
  end

  // shared multiply-accumulate: corner weights, then frequency weights
  always_comb begin
    case (step_q)
      3'd4:    mul_a = acc_q[MA_W-1:0];
      3'd5:    mul_a = f1_q;
      default: mul_a = $signed({{(MA_W-rfpwr_pkg::TARGET_W){1'b0}}, rom_q});
    endcase
    case (step_q)
      3'd0, 3'd2: mul_b = dxh_q;
      3'd1, 3'd3: mul_b = dxl_q;
      3'd4:       mul_b = $signed({{(MB_W-6){1'b0}}, dyl_q});
      3'd5:       mul_b = $signed({{(MB_W-6){1'b0}}, dyh_q});
      default:    mul_b = '0;
    endcase
    prod  = mul_a * mul_b;
    acc_d = (step_q[0] ? acc_q : '0) + {prod[MA_W+MB_W-1], prod};
  end

  // divider: range check against den*2048, then one quotient bit a cycle
  assign den     = rfpwr_pkg::seg_den(pr_q);
  assign num_ovf = acc_q >= $signed({{(ACC_W-REM_W-1){1'b0}}, den, 11'b0});
  assign trial   = {1'b0, rem_q} - {{(REM_W-DSR_W+1){1'b0}}, dsr_q};

  // result of the item at write-back
  always_comb begin
    pwm_d    = pwm_q;
    target_d = target_q;
    amp_d    = amp_q;
    if (cmd_q == rfpwr_pkg::CMD_TICK) begin
      if ({1'b0, sample_q} > {2'b00, target_q}) begin
        if (pwm_q < pwm_hi_q) pwm_d = pwm_q + 1'b1;
      end else if ({1'b0, sample_q} < {2'b00, target_q}) begin
        if (pwm_q > pwm_lo_q) pwm_d = pwm_q - 1'b1;
      end
    end else if (level_q < rfpwr_pkg::LEVEL_OFF_Q4) begin
      target_d = '0;
      pwm_d    = pwm_hi_q;
      amp_d    = 1'b0;
    end else if (level_q > rfpwr_pkg::LEVEL_MAX_Q4) begin
      target_d = rfpwr_pkg::OVERDRIVE_TARGET;
      pwm_d    = pwm_lo_q;
      amp_d    = 1'b1;
    end else if (level_q == rfpwr_pkg::LEVEL_MAX_Q4) begin
      target_d = rom_q;
      amp_d    = 1'b1;
    end else begin
      target_d = calc_q;
      amp_d    = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = need_interp ? ST_MAC : ST_OUT;
      ST_MAC:  if (step_q == MAC_LAST) state_d = ST_CHK;
      ST_CHK:  state_d = (acc_q[ACC_W-1] || num_ovf) ? ST_OUT : ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      freq_q      <= rfpwr_pkg::FREQ_RESET;
      pwm_lo_q    <= rfpwr_pkg::PWM_LOW_RESET;
      pwm_hi_q    <= rfpwr_pkg::PWM_HIGH_RESET;
      pwm_q       <= rfpwr_pkg::PWM_HIGH_RESET;
      target_q    <= '0;
      amp_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        pwm_q       <= pwm_d;
        target_q    <= target_d;
        amp_q       <= amp_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rfpwr_pkg::REG_FREQ:     freq_q   <= cfg_data_i;
          rfpwr_pkg::REG_PWM_LOW:  pwm_lo_q <= cfg_data_i[rfpwr_pkg::PWM_W-1:0];
          rfpwr_pkg::REG_PWM_HIGH: pwm_hi_q <= cfg_data_i[rfpwr_pkg::PWM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= in_data_i.cmd;
      level_q  <= in_data_i.power_dbm_q4;
      sample_q <= in_data_i.detector_sample;
      pr_q     <= pr_d;
      fc_q     <= fc_d;
      ctop_q   <= ctop_d;
      dxh_q    <= dxh_d;
      dxl_q    <= dxl_d;
      dyh_q    <= dyh_d;
      dyl_q    <= dyl_d;
      step_q   <= '0;
    end
    case (state_q)
      ST_MAC: begin
        acc_q  <= acc_d;
        step_q <= step_q + 3'd1;
        if (step_q == 3'd2) f1_q <= acc_q[MA_W-1:0];
      end
      ST_CHK: begin
        rem_q  <= acc_q[REM_W-1:0];
        dsr_q  <= {den, 10'b0};
        cnt_q  <= DIV_FIRST;
        calc_q <= acc_q[ACC_W-1] ? '0 : rfpwr_pkg::TARGET_MAX;
      end
      ST_DIV: begin
        if (!trial[REM_W]) rem_q <= trial[REM_W-1:0];
        dsr_q  <= dsr_q >> 1;
        cnt_q  <= cnt_q - 4'd1;
        calc_q <= {calc_q[rfpwr_pkg::TARGET_W-2:0], ~trial[REM_W]};
      end
      ST_OUT: begin
        if (out_free) out_q <= '{pwm_duty: pwm_d, amp_enable: amp_d,
                                 detector_target: target_d};
      end
      default: ;
    endcase
  end

  // checks
  `RFP_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
                   "input taken while an item is in flight")
  `RFP_ASSERT(a_div_bound, clk_i, rst_ni,
              (state_q != ST_DIV) || (rem_q < {dsr_q, 1'b0}),
              "divider remainder out of range")
  `RFP_ASSERT(a_off_target, clk_i, rst_ni, amp_q || (target_q == '0),
              "set-point nonzero with amplifier off")
  `RFP_ASSERT(a_beat_source, clk_i, rst_ni,
              $rose(out_valid_q) |-> ($past(state_q) == ST_OUT),
              "output beat loaded outside write-back")

endmodule

// ===== tb/rf_power_checker.sv =====
// ----------------------------------------------------------------------------
// rfpwr_setpoint_checker
// watches the beat channels and register writes of the tx power regulator,
// keeps its own copy of set-point, pwm and amplifier state, predicts every
// result beat and compares it field by field in order of arrival
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfpwr_setpoint_checker
  import rfpwr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  rfpwr_in_t             in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  rfpwr_out_t            out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output logic [TARGET_W-1:0]   target_o
);

  // predicted register and loop state
  logic [FREQ_W-1:0]   freq_q;
  logic [PWM_W-1:0]    pwm_low_q;
  logic [PWM_W-1:0]    pwm_high_q;
  logic [PWM_W-1:0]    pwm_q;
  logic [TARGET_W-1:0] target_q;
  logic                amp_q;

  // result beats still owed by the block, oldest first
  rfpwr_out_t setpoint_beats[$];

  // highest grid column at or below f, never above top
  function automatic int column_at_or_below(input int f, input int top);
    int col;
    col = 0;
    for (int i = 1; i <= top; i++) begin
      if (f >= FREQ_MIN + FREQ_STEP * i) col = i;
    end
    return col;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    rfpwr_out_t want;
    longint     lvl, frq, x1, x2, y1, y2;
    longint     q11, q12, q21, q22, f1, f2, quo;
    int         fcol, prow;
    if (!rst_ni) begin
      freq_q       = FREQ_RESET;
      pwm_low_q    = PWM_LOW_RESET;
      pwm_high_q   = PWM_HIGH_RESET;
      pwm_q        = PWM_HIGH_RESET;
      target_q     = '0;
      amp_q        = 1'b0;
      fail_count_o = 0;
      setpoint_beats.delete();
      pending_o    <= 0;
      target_o     <= '0;
    end else begin
      // compare a result beat with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (setpoint_beats.size() == 0) begin
          $error("result beat with nothing expected: pwm_duty %0d amp_enable %0d target %0d",
                 out_data_i.pwm_duty, out_data_i.amp_enable, out_data_i.detector_target);
          fail_count_o++;
        end else begin
          want = setpoint_beats.pop_front();
          if (out_data_i.pwm_duty !== want.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_data_i.pwm_duty);
            fail_count_o++;
          end
          if (out_data_i.amp_enable !== want.amp_enable) begin
            $error("amp_enable: expected %0d, got %0d", want.amp_enable,
                   out_data_i.amp_enable);
            fail_count_o++;
          end
          if (out_data_i.detector_target !== want.detector_target) begin
            $error("detector_target: expected %0d, got %0d", want.detector_target,
                   out_data_i.detector_target);
            fail_count_o++;
          end
        end
      end

      // register writes, unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FREQ:     freq_q     = cfg_data_i[FREQ_W-1:0];
          REG_PWM_LOW:  pwm_low_q  = cfg_data_i[PWM_W-1:0];
          REG_PWM_HIGH: pwm_high_q = cfg_data_i[PWM_W-1:0];
          default: ;
        endcase
      end

      // input beat: update state and queue the result it causes
      if (in_valid_i && in_ready_i) begin
        frq = (freq_q < FREQ_MIN) ? FREQ_MIN : ((freq_q > FREQ_MAX) ? FREQ_MAX : freq_q);
        if (in_data_i.cmd == CMD_SET_POWER) begin
          if (in_data_i.power_dbm_q4 < LEVEL_OFF_Q4) begin
            // amplifier off
            target_q = '0;
            pwm_q    = pwm_high_q;
            amp_q    = 1'b0;
          end else if (in_data_i.power_dbm_q4 > LEVEL_MAX_Q4) begin
            // overdrive
            target_q = OVERDRIVE_TARGET;
            pwm_q    = pwm_low_q;
            amp_q    = 1'b1;
          end else if (in_data_i.power_dbm_q4 == LEVEL_MAX_Q4) begin
            // top row read straight, last column reachable at 6000 MHz
            target_q = CAL_ROM[POWER_POINTS-1][column_at_or_below(int'(frq), FREQ_POINTS - 1)];
            amp_q    = 1'b1;
          end else begin
            // bilinear interpolation, one truncating division
            lvl  = longint'(in_data_i.power_dbm_q4) + DB_OFFSET_Q4;
            fcol = column_at_or_below(int'(frq), FREQ_POINTS - 2);
            prow = POWER_POINTS - 2;
            for (int i = POWER_POINTS - 2; i >= 0; i--) begin
              if (lvl < 16 * longint'(GRID_DBM[i+1])) prow = i;
            end
            x1  = 16 * longint'(GRID_DBM[prow]);
            x2  = 16 * longint'(GRID_DBM[prow+1]);
            y1  = FREQ_MIN + FREQ_STEP * fcol;
            y2  = y1 + FREQ_STEP;
            q11 = CAL_ROM[prow][fcol];
            q12 = CAL_ROM[prow][fcol+1];
            q21 = CAL_ROM[prow+1][fcol];
            q22 = CAL_ROM[prow+1][fcol+1];
            f1  = q11 * (x2 - lvl) + q21 * (lvl - x1);
            f2  = q12 * (x2 - lvl) + q22 * (lvl - x1);
            quo = (f1 * (y2 - frq) + f2 * (frq - y1)) / ((x2 - x1) * (y2 - y1));
            if (quo < 0) target_q = '0;
            else if (quo > longint'(TARGET_MAX)) target_q = TARGET_MAX;
            else target_q = quo[TARGET_W-1:0];
            amp_q = 1'b1;
          end
        end else begin
          // control tick: one pwm step toward balance inside the limits
          if (in_data_i.detector_sample > target_q) begin
            if (pwm_q < pwm_high_q) pwm_q = pwm_q + 1'b1;
          end else if (in_data_i.detector_sample < target_q) begin
            if (pwm_q > pwm_low_q) pwm_q = pwm_q - 1'b1;
          end
        end
        want.pwm_duty        = pwm_q;
        want.amp_enable      = amp_q;
        want.detector_target = target_q;
        setpoint_beats.push_back(want);
      end

      pending_o <= setpoint_beats.size();
      target_o  <= target_q;
    end
  end

endmodule

// ===== tb/tb_rf_power_setpoint_and_bias_loop.sv =====
// ----------------------------------------------------------------------------
// tb_rf_power_setpoint_and_bias_loop
// drives set-power and tick beats into the tx power regulator with random
// gaps and output stalls, reprograms frequency and pwm limits between phases
// and leaves prediction and comparison to rfpwr_setpoint_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rf_power_setpoint_and_bias_loop;
  import rfpwr_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 38;
  localparam int PHASES       = 9;
  localparam int PHASE_BEATS  = 84;
  localparam int CALM_PHASE   = 5;
  localparam int PAUSE_PHASE  = 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int END_CYCLES   = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  rfpwr_in_t             in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  rfpwr_out_t            out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int                  fail_total;
  int                  pending_beats;
  logic [TARGET_W-1:0] target_hint;
  int                  quiet_cycles = 0;
  int                  n_set        = 0;
  int                  n_tick       = 0;
  logic                calm         = 1'b0;

  // register settings per phase, the last two are drawn at random
  int phase_freq [PHASES] = '{5600, 6000, 0, 8191, 5599, 6001, 5725, 0, 0};
  int phase_low  [PHASES] = '{10, 2040, 0, 4095, 3000, 2400, 1990, 0, 0};
  int phase_high [PHASES] = '{20, 2060, 4095, 0, 3005, 2600, 2010, 0, 0};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  rf_power_setpoint_and_bias_loop dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  rfpwr_setpoint_checker u_setpoint_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_total),
    .pending_o    (pending_beats),
    .target_o     (target_hint)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog: cycles with work outstanding but no beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (!in_valid_i && pending_beats == 0) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("tb_rf_power_setpoint_and_bias_loop: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic rfpwr_in_t make_beat(input logic cmd, input int lvl, input int smp);
    rfpwr_in_t beat;
    beat.cmd             = cmd;
    beat.power_dbm_q4    = LEVEL_W'(lvl);
    beat.detector_sample = SAMPLE_W'(smp);
    return beat;
  endfunction

  // random beat: levels mostly inside the grid, samples often near the set-point
  function automatic rfpwr_in_t random_beat();
    rfpwr_in_t beat;
    int        pick;
    int        t;
    beat.cmd             = ($urandom_range(0, 99) < 35) ? CMD_SET_POWER : CMD_TICK;
    beat.power_dbm_q4    = LEVEL_W'($urandom_range(0, 1023));
    beat.detector_sample = SAMPLE_W'($urandom_range(0, 4095));
    pick = $urandom_range(0, 9);
    if (beat.cmd == CMD_SET_POWER) begin
      case (pick)
        0, 1, 2, 3, 4: beat.power_dbm_q4 = LEVEL_W'($urandom_range(320, 512));
        5:             beat.power_dbm_q4 = {GRID_DBM[$urandom_range(0, POWER_POINTS - 1)],
                                            4'b0000};
        6:             beat.power_dbm_q4 = LEVEL_W'($urandom_range(0, 319));
        7:             beat.power_dbm_q4 = LEVEL_W'($urandom_range(513, 1023));
        default: ;
      endcase
    end else if (pick < 4) begin
      t = int'(target_hint) + int'($urandom_range(0, 6)) - 3;
      beat.detector_sample = SAMPLE_W'((t < 0) ? 0 : t);
    end else if (pick == 4) begin
      beat.detector_sample = $urandom_range(0, 1) ? '1 : '0;
    end
    return beat;
  endfunction

  // one input beat, with an optional gap in front
  task automatic send_beat(input rfpwr_in_t beat);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (beat.cmd == CMD_SET_POWER) n_set++;
    else n_tick++;
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
  endtask

  // a spare index write first, it must be ignored
  task automatic set_regs(input int freq, input int low, input int high);
    write_reg(REG_SPARE, $urandom_range(0, 8191));
    write_reg(REG_FREQ, freq);
    write_reg(REG_PWM_LOW, low);
    write_reg(REG_PWM_HIGH, high);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats at reset register values
    send_beat(make_beat(CMD_SET_POWER, 0, $urandom_range(0, 4095)));
    send_beat(make_beat(CMD_TICK, $urandom_range(0, 1023), 4095));
    send_beat(make_beat(CMD_TICK, $urandom_range(0, 1023), 0));
    send_beat(make_beat(CMD_SET_POWER, 319, $urandom_range(0, 4095)));
    send_beat(make_beat(CMD_SET_POWER, 320, $urandom_range(0, 4095)));
    send_beat(make_beat(CMD_TICK, $urandom_range(0, 1023), 0));
    send_beat(make_beat(CMD_TICK, $urandom_range(0, 1023), 4095));
    send_beat(make_beat(CMD_SET_POWER, 367, 0));
    send_beat(make_beat(CMD_SET_POWER, 368, 4095));
    send_beat(make_beat(CMD_SET_POWER, 369, 0));
    send_beat(make_beat(CMD_SET_POWER, 416, 0));
    send_beat(make_beat(CMD_SET_POWER, 448, 0));
    send_beat(make_beat(CMD_SET_POWER, 464, 0));
    send_beat(make_beat(CMD_SET_POWER, 496, 0));
    send_beat(make_beat(CMD_SET_POWER, 511, 0));
    send_beat(make_beat(CMD_SET_POWER, 512, 0));
    send_beat(make_beat(CMD_TICK, 0, 2047));
    send_beat(make_beat(CMD_SET_POWER, 513, 4095));
    send_beat(make_beat(CMD_TICK, 1023, int'(OVERDRIVE_TARGET)));
    send_beat(make_beat(CMD_TICK, 1023, 4095));
    send_beat(make_beat(CMD_TICK, 0, 0));
    send_beat(make_beat(CMD_SET_POWER, 1023, 0));
    send_beat(make_beat(CMD_SET_POWER, 400, 0));
    send_beat(make_beat(CMD_TICK, 0, 2048));
    send_beat(make_beat(CMD_SET_POWER, 0, 0));
    drain_results();

    // random phases, registers rewritten only while the block is idle
    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) begin
        phase_freq[p] = (p == PHASES - 1) ? $urandom_range(0, 8191) : $urandom_range(5550, 6050);
        phase_low[p]  = $urandom_range(1800, 2300);
        phase_high[p] = phase_low[p] + $urandom_range(0, 300);
      end
      calm = (p == CALM_PHASE);
      set_regs(phase_freq[p], phase_low[p], phase_high[p]);
      // grid edges at the new frequency first
      send_beat(make_beat(CMD_SET_POWER, 320, $urandom_range(0, 4095)));
      send_beat(make_beat(CMD_SET_POWER, 511, $urandom_range(0, 4095)));
      send_beat(make_beat(CMD_SET_POWER, 512, $urandom_range(0, 4095)));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p == PAUSE_PHASE && n == PHASE_BEATS / 2) drain_results();
        send_beat(random_beat());
      end
      drain_results();
    end

    calm = 1'b0;
    repeat (END_CYCLES) @(posedge clk_i);
    $display("covered %0d set-power and %0d tick beats over %0d register settings",
             n_set, n_tick, PHASES + 1);
    $display("frequencies 0..8191 MHz, pwm limits 0..4095 including inverted, %0d mismatches",
             fail_total);
    if (fail_total == 0 && pending_beats == 0) begin
      $display("tb_rf_power_setpoint_and_bias_loop: PASS");
    end else begin
      $display("tb_rf_power_setpoint_and_bias_loop: FAIL");
    end
    $finish;
  end

endmodule
